/* rtl/packet_duplicate_filter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the duplicate filter
// Concurrent checks clocked on clock, held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PACKET_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define PACKET_DUPLICATE_FILTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PKTDUP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pktdup: assertion failed");
`define PKTDUP_ASSERT_MSG(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`else
`define PKTDUP_ASSERT(label, prop)
`define PKTDUP_ASSERT_MSG(label, prop, msg)
`endif
`endif

/* rtl/pktdup_pkg.sv */
// ----------------------------------------------------------------------------
// pktdup_pkg
// Sizes, codes and types shared by the duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pktdup_pkg;

   localparam int RECORD_BYTES = 43;
   localparam int HEADER_BYTES = 4;
   localparam int GATEWAYS     = 2;
   localparam int DEVICES      = 128;

   localparam int TOTAL_BYTES = HEADER_BYTES + RECORD_BYTES;
   localparam int RECORD_W    = RECORD_BYTES * 8;
   localparam int ROWS        = GATEWAYS * DEVICES;
   localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int GW_W        = (GATEWAYS > 1) ? $clog2(GATEWAYS) : 1;
   localparam int DEV_W       = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   localparam logic [7:0] POS_VERSION = 8'd0;
   localparam logic [7:0] POS_LENGTH  = 8'd1;
   localparam logic [7:0] POS_GATEWAY = 8'd2;
   localparam logic [7:0] POS_TYPE    = 8'd3;
   localparam logic [7:0] POS_RECORD  = 8'(HEADER_BYTES);
   localparam logic [7:0] POS_END     = 8'(TOTAL_BYTES);
   localparam logic [7:0] COUNT_MAX   = 8'd255;

   typedef logic [2:0]          status_type;
   typedef logic [RECORD_W-1:0] record_type;
   typedef logic [ROW_AW-1:0]   row_addr_type;

   localparam status_type ST_NEW = 3'd0;
   localparam status_type ST_DUP = 3'd1;
   localparam status_type ST_LEN = 3'd2;
   localparam status_type ST_HDR = 3'd3;
   localparam status_type ST_GW  = 3'd4;
   localparam status_type ST_DEV = 3'd5;

   localparam logic [1:0] CSR_VERSION   = 2'd0;
   localparam logic [1:0] CSR_TYPE      = 2'd1;
   localparam logic [1:0] CSR_GW_LIMIT  = 2'd2;
   localparam logic [1:0] CSR_DEV_LIMIT = 2'd3;

   localparam logic [7:0] VERSION_RESET   = 8'h12;
   localparam logic [7:0] TYPE_RESET      = 8'd0;
   localparam logic [1:0] GW_LIMIT_RESET  = 2'd2;
   localparam logic [7:0] DEV_LIMIT_RESET = 8'd100;

endpackage

`default_nettype wire

/* rtl/pktdup_ram.sv */
// ----------------------------------------------------------------------------
// pktdup_ram
// Single-port synchronous RAM, read-first, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pktdup_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                             wdata,
   output logic      [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/packet_duplicate_filter_top.sv */
// ----------------------------------------------------------------------------
// packet_duplicate_filter_top
// Byte-serial datagram checker that keeps the last record per gateway and
// device in a row-wide history RAM and flags repeated records.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while start is high and busy is low. After the final
// byte busy is high through the judge state (rejected datagram) or through the
// judge and compare states (history row read and compared), and rsp_valid
// strobes in the cycle after that. The registered history RAM read sets the extra state.
// After reset busy stays high while all ROWS (256) RAM rows are zeroed.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

`include "packet_duplicate_filter_top_assert.svh"

module packet_duplicate_filter_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_gateway_id,
   output logic [7:0]      rsp_device_id,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CLEAR   = 2'd1;
   localparam logic [1:0] ST_JUDGE   = 2'd2;
   localparam logic [1:0] ST_COMPARE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [7:0] version_ff, type_ff, dev_limit_ff;
   logic [1:0] gw_limit_ff;

   logic [7:0] count_ff, count_in;
   logic       hdr_bad_ff, hdr_bad_in;
   logic [7:0] gw_ff, gw_in;
   logic [7:0] dev_ff, dev_in;
   pktdup_pkg::record_type   record_ff, record_in;
   pktdup_pkg::row_addr_type clear_ff, clear_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   pktdup_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_gw_ff, rsp_gw_in;
   logic [7:0]             rsp_dev_ff, rsp_dev_in;

   logic                     accept;
   logic                     gw_bad, dev_bad, differs;
   pktdup_pkg::row_addr_type row_addr, ram_addr;
   logic                     ram_we;
   pktdup_pkg::record_type   ram_wdata, ram_rdata;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign gw_bad  = (gw_ff >= {6'd0, gw_limit_ff}) || (gw_ff >= 8'(pktdup_pkg::GATEWAYS));
   assign dev_bad = (dev_ff >= dev_limit_ff) || ({1'b0, dev_ff} >= 9'(pktdup_pkg::DEVICES));
   assign row_addr = pktdup_pkg::row_addr_type'(
                        pktdup_pkg::row_addr_type'(gw_ff[pktdup_pkg::GW_W-1:0])
                        * pktdup_pkg::row_addr_type'(pktdup_pkg::DEVICES)
                        + pktdup_pkg::row_addr_type'(dev_ff[pktdup_pkg::DEV_W-1:0]));
   assign differs = (ram_rdata != record_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      hdr_bad_in    = hdr_bad_ff;
      gw_in         = gw_ff;
      dev_in        = dev_ff;
      record_in     = record_ff;
      clear_in      = clear_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_gw_in     = rsp_gw_ff;
      rsp_dev_in    = rsp_dev_ff;
      ram_we        = 1'b0;
      ram_addr      = row_addr;
      ram_wdata     = record_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clear_ff;
            ram_wdata = '0;
            clear_in  = clear_ff + 1'b1;
            if (clear_ff == pktdup_pkg::row_addr_type'(pktdup_pkg::ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (count_ff == pktdup_pkg::POS_VERSION && req_data_byte != version_ff) begin
                  hdr_bad_in = 1'b1;
               end else if (count_ff == pktdup_pkg::POS_LENGTH
                            && req_data_byte != pktdup_pkg::POS_END) begin
                  hdr_bad_in = 1'b1;
               end else if (count_ff == pktdup_pkg::POS_GATEWAY) begin
                  gw_in = req_data_byte;
               end else if (count_ff == pktdup_pkg::POS_TYPE && req_data_byte != type_ff) begin
                  hdr_bad_in = 1'b1;
               end else if (count_ff >= pktdup_pkg::POS_RECORD
                            && count_ff < pktdup_pkg::POS_END) begin
                  record_in = {record_ff[pktdup_pkg::RECORD_W-9:0], req_data_byte};
                  if (count_ff == pktdup_pkg::POS_RECORD) begin
                     dev_in = req_data_byte;
                  end
               end
               if (count_ff != pktdup_pkg::COUNT_MAX) begin
                  count_in = count_ff + 8'd1;
               end
               if (req_last_byte) begin
                  state_in = ST_JUDGE;
               end
            end
         end
         ST_JUDGE: begin
            rsp_gw_in  = gw_ff;
            rsp_dev_in = dev_ff;
            priority if (count_ff != pktdup_pkg::POS_END) begin
               rsp_status_in = pktdup_pkg::ST_LEN;
            end else if (hdr_bad_ff) begin
               rsp_status_in = pktdup_pkg::ST_HDR;
            end else if (gw_bad) begin
               rsp_status_in = pktdup_pkg::ST_GW;
            end else if (dev_bad) begin
               rsp_status_in = pktdup_pkg::ST_DEV;
            end else begin
               rsp_status_in = rsp_status_ff;
            end
            if (count_ff != pktdup_pkg::POS_END || hdr_bad_ff || gw_bad || dev_bad) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               hdr_bad_in   = 1'b0;
               gw_in        = '0;
               dev_in       = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ram_we        = differs;
            rsp_valid_in  = 1'b1;
            rsp_status_in = differs ? pktdup_pkg::ST_NEW : pktdup_pkg::ST_DUP;
            count_in      = '0;
            hdr_bad_in    = 1'b0;
            gw_in         = '0;
            dev_in        = '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         count_ff     <= '0;
         hdr_bad_ff   <= 1'b0;
         gw_ff        <= '0;
         dev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         version_ff   <= pktdup_pkg::VERSION_RESET;
         type_ff      <= pktdup_pkg::TYPE_RESET;
         gw_limit_ff  <= pktdup_pkg::GW_LIMIT_RESET;
         dev_limit_ff <= pktdup_pkg::DEV_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         count_ff     <= count_in;
         hdr_bad_ff   <= hdr_bad_in;
         gw_ff        <= gw_in;
         dev_ff       <= dev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               pktdup_pkg::CSR_VERSION:   version_ff   <= csr_wdata;
               pktdup_pkg::CSR_TYPE:      type_ff      <= csr_wdata;
               pktdup_pkg::CSR_GW_LIMIT:  gw_limit_ff  <= csr_wdata[1:0];
               pktdup_pkg::CSR_DEV_LIMIT: dev_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      record_ff     <= record_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gw_ff     <= rsp_gw_in;
      rsp_dev_ff    <= rsp_dev_in;
   end

   pktdup_ram #(
      .WIDTH (pktdup_pkg::RECORD_W),
      .DEPTH (pktdup_pkg::ROWS)
   ) u_history (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_gateway_id = rsp_gw_ff;
   assign rsp_device_id  = rsp_dev_ff;

   `PKTDUP_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid)
   `PKTDUP_ASSERT(a_last_to_judge, (accept && req_last_byte) |=> (state_ff == ST_JUDGE))
   `PKTDUP_ASSERT_MSG(a_write_new, (ram_we && state_ff == ST_COMPARE) |=> (rsp_valid && rsp_status == pktdup_pkg::ST_NEW), "pktdup: history write without new status")

endmodule

`default_nettype wire
